// File: design/box_filter_2d_unit_macros.svh
// Assertion macros used by the box filter RTL.
// Define ASSERT_OFF to compile the assertions out.
`ifndef BOX_FILTER_2D_UNIT_MACROS_SVH
`define BOX_FILTER_2D_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define BF2D_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BF2D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define BF2D_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define BF2D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: design/bf2d_pkg.sv
package bf2d_pkg;

   localparam int MAX_RADIUS = 8;
   localparam int MAX_WIDTH  = 1024;
   localparam int PIXEL_BITS = 8;

   localparam int TWO_R_MAX  = 2 * MAX_RADIUS;
   localparam int WIN_COLS   = TWO_R_MAX + 1;
   localparam int LINE_LEN   = MAX_WIDTH + TWO_R_MAX;
   localparam int COL_BITS   = $clog2(LINE_LEN);
   localparam int LINE_BITS  = $clog2(LINE_LEN + 1);
   localparam int TWO_R_BITS = $clog2(TWO_R_MAX + 1);
   localparam int CSUM_BITS  = PIXEL_BITS + $clog2(TWO_R_MAX + 1);
   localparam int WSUM_BITS  = PIXEL_BITS + $clog2(WIN_COLS * WIN_COLS);

   // Register field widths.
   localparam int RADIUS_BITS    = 4;
   localparam int WIDTH_BITS     = 11;
   localparam int RECIP_BITS     = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECIP  = 2'd2;

   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 4'd1;
   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [RECIP_BITS-1:0]  RECIP_RESET  = 16'd7282;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic                  frame_end;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] filtered;
      logic                  last;
   } rsp_payload_type;

   // One column of the line store: the last 2r pixels and their sum.
   typedef struct packed {
      logic [TWO_R_MAX-1:0][PIXEL_BITS-1:0] rows;
      logic [CSUM_BITS-1:0]                 csum;
   } col_word_type;

   typedef struct packed {
      logic                en;
      logic [COL_BITS-1:0] addr;
   } col_rd_type;

   typedef struct packed {
      logic                en;
      logic [COL_BITS-1:0] addr;
      col_word_type        data;
   } col_wr_type;

endpackage

// File: design/bf2d_col_store.sv
module bf2d_col_store (
   input  logic                  clock,
   input  bf2d_pkg::col_rd_type  rd,
   input  bf2d_pkg::col_wr_type  wr,
   output bf2d_pkg::col_word_type rd_data
);

   bf2d_pkg::col_word_type mem [bf2d_pkg::LINE_LEN];
   bf2d_pkg::col_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // A read of the column being written in the same cycle returns the new word.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         if (wr.en && (wr.addr == rd.addr)) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem[rd.addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/box_filter_2d_unit.sv
// Channel   Ports                             Moves
// req       req_valid/req_ready, req_data     one bordered pixel, raster order
// rsp       rsp_valid/rsp_ready, rsp_data     one filtered pixel per full window
// csr       csr_we, csr_index, csr_wdata      radius, image width, reciprocal
//
// One request is taken every cycle while the column stage can move on: the column
// memory reads at acceptance and writes the updated column through its separate
// write port when the column stage moves on. A result passes from the column stage
// through the normalize register into the output register.
// Synchronous reset clears position, row count, window and pipeline valids;
// the column store is not cleared. A stalled rsp holds the pipeline stage by
// stage, and req_ready drops only when the column stage cannot move on.
`include "box_filter_2d_unit_macros.svh"

module box_filter_2d_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  bf2d_pkg::req_payload_type             req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output bf2d_pkg::rsp_payload_type             rsp_data,
   input  logic                                  csr_we,
   input  logic [bf2d_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bf2d_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int PROD_BITS  = bf2d_pkg::WSUM_BITS + bf2d_pkg::RECIP_BITS + 1;
   localparam int ROUND_HALF = 1 << (bf2d_pkg::RECIP_BITS - 1);
   localparam int PIX_MAX    = (1 << bf2d_pkg::PIXEL_BITS) - 1;

   // Configuration registers.
   logic [bf2d_pkg::RADIUS_BITS-1:0] radius_ff;
   logic [bf2d_pkg::WIDTH_BITS-1:0]  width_ff;
   logic [bf2d_pkg::RECIP_BITS-1:0]  recip_ff;

   // Front stage: position in the padded frame.
   logic [bf2d_pkg::COL_BITS-1:0]   column_position_ff, column_position_in;
   logic [bf2d_pkg::TWO_R_BITS-1:0] rows_filled_ff, rows_filled_in;
   logic [bf2d_pkg::TWO_R_BITS-1:0] r_eff, two_r_a, f_a;
   logic [bf2d_pkg::LINE_BITS-1:0]  w_eff, line_a, x_next_a;
   logic [bf2d_pkg::COL_BITS-1:0]   x_a;
   logic                            last_col_a;
   logic                            accept;

   // Column stage.
   logic                            b_v_ff, b_v_in;
   logic [bf2d_pkg::COL_BITS-1:0]   b_x_ff;
   logic [bf2d_pkg::TWO_R_BITS-1:0] b_f_ff, b_two_r_ff;
   logic [bf2d_pkg::PIXEL_BITS-1:0] b_pixel_ff;
   logic                            b_fend_ff;
   logic                            b_full, b_has_out, b_go;
   logic [bf2d_pkg::CSUM_BITS-1:0]  b_col_total;
   logic [bf2d_pkg::TWO_R_MAX-1:0][bf2d_pkg::PIXEL_BITS-1:0] rows_up;
   bf2d_pkg::col_word_type          col_rd_data, col_new;
   bf2d_pkg::col_rd_type            col_rd;
   bf2d_pkg::col_wr_type            col_wr;

   // Horizontal window.
   logic [bf2d_pkg::CSUM_BITS-1:0]  win_col_ff [bf2d_pkg::WIN_COLS];
   logic [bf2d_pkg::CSUM_BITS-1:0]  win_col_in [bf2d_pkg::WIN_COLS];
   logic [bf2d_pkg::WSUM_BITS-1:0]  win_sum_ff, win_sum_in, win_sum_next, win_base;

   // Normalize stage and output register.
   logic                            m_v_ff, m_v_in, m_go, m_free;
   logic [bf2d_pkg::WSUM_BITS-1:0]  m_sum_ff;
   logic                            m_last_ff;
   logic [PROD_BITS-1:0]            m_prod, m_quot;
   logic                            out_v_ff, out_v_in, out_free;
   bf2d_pkg::rsp_payload_type       rsp_data_ff, rsp_data_in;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= bf2d_pkg::RADIUS_RESET;
         width_ff  <= bf2d_pkg::WIDTH_RESET;
         recip_ff  <= bf2d_pkg::RECIP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            bf2d_pkg::CSR_RADIUS: radius_ff <= csr_wdata[bf2d_pkg::RADIUS_BITS-1:0];
            bf2d_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[bf2d_pkg::WIDTH_BITS-1:0];
            bf2d_pkg::CSR_RECIP:  recip_ff  <= csr_wdata[bf2d_pkg::RECIP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- control
   assign out_free  = !out_v_ff || rsp_ready;
   assign m_go      = m_v_ff && out_free;
   assign m_free    = !m_v_ff || out_free;
   assign b_go      = b_v_ff && (!b_has_out || m_free);
   assign req_ready = !b_v_ff || b_go;
   assign accept    = req_valid && req_ready;

   // ---------------------------------------------------------------- front
   always_comb begin
      if (radius_ff == '0) begin
         r_eff = bf2d_pkg::TWO_R_BITS'(1);
      end else if (radius_ff > bf2d_pkg::MAX_RADIUS) begin
         r_eff = bf2d_pkg::TWO_R_BITS'(bf2d_pkg::MAX_RADIUS);
      end else begin
         r_eff = bf2d_pkg::TWO_R_BITS'(radius_ff);
      end
      two_r_a = r_eff << 1;

      if (width_ff > bf2d_pkg::MAX_WIDTH) begin
         w_eff = bf2d_pkg::LINE_BITS'(bf2d_pkg::MAX_WIDTH);
      end else begin
         w_eff = bf2d_pkg::LINE_BITS'(width_ff);
      end
      line_a = bf2d_pkg::LINE_BITS'(w_eff + bf2d_pkg::LINE_BITS'(two_r_a));

      // A position left beyond a shortened line restarts the line.
      if (bf2d_pkg::LINE_BITS'(column_position_ff) >= line_a) begin
         x_a = '0;
      end else begin
         x_a = column_position_ff;
      end
      f_a = (rows_filled_ff > two_r_a) ? two_r_a : rows_filled_ff;

      x_next_a   = bf2d_pkg::LINE_BITS'(bf2d_pkg::LINE_BITS'(x_a) + 1'b1);
      last_col_a = (x_next_a >= line_a);

      column_position_in = column_position_ff;
      rows_filled_in     = rows_filled_ff;
      if (accept) begin
         if (req_data.frame_end) begin
            column_position_in = '0;
            rows_filled_in     = '0;
         end else if (last_col_a) begin
            column_position_in = '0;
            rows_filled_in     = (f_a < two_r_a) ?
                                 bf2d_pkg::TWO_R_BITS'(f_a + 1'b1) : f_a;
         end else begin
            column_position_in = x_next_a[bf2d_pkg::COL_BITS-1:0];
            rows_filled_in     = f_a;
         end
      end
   end

   assign col_rd.en   = accept;
   assign col_rd.addr = x_a;

   bf2d_col_store u_col_store (
      .clock   (clock),
      .rd      (col_rd),
      .wr      (col_wr),
      .rd_data (col_rd_data)
   );

   // ---------------------------------------------------------------- column stage
   always_comb begin
      b_full      = (b_f_ff == b_two_r_ff);
      b_has_out   = b_full && (b_x_ff >= bf2d_pkg::COL_BITS'(b_two_r_ff));
      b_col_total = bf2d_pkg::CSUM_BITS'(col_rd_data.csum +
                                         bf2d_pkg::CSUM_BITS'(b_pixel_ff));
      rows_up     = col_rd_data.rows >> bf2d_pkg::PIXEL_BITS;

      col_new = col_rd_data;
      if (b_full) begin
         // Drop the oldest row, append the new pixel at the top of the chain.
         col_new.csum = bf2d_pkg::CSUM_BITS'(b_col_total -
                                             bf2d_pkg::CSUM_BITS'(col_rd_data.rows[0]));
         for (int k = 0; k < bf2d_pkg::TWO_R_MAX; k++) begin
            if (k + 1 < b_two_r_ff) begin
               col_new.rows[k] = rows_up[k];
            end else if (k + 1 == b_two_r_ff) begin
               col_new.rows[k] = b_pixel_ff;
            end
         end
      end else begin
         col_new.csum = (b_f_ff == '0) ? bf2d_pkg::CSUM_BITS'(b_pixel_ff) : b_col_total;
         for (int k = 0; k < bf2d_pkg::TWO_R_MAX; k++) begin
            if (k == b_f_ff) begin
               col_new.rows[k] = b_pixel_ff;
            end
         end
      end
   end

   assign col_wr.en   = b_go;
   assign col_wr.addr = b_x_ff;
   assign col_wr.data = col_new;

   // ---------------------------------------------------------------- window
   always_comb begin
      win_base = (b_x_ff == '0) ? '0 : win_sum_ff;
      for (int k = 0; k < bf2d_pkg::WIN_COLS; k++) begin
         win_col_in[k] = win_col_ff[k];
      end
      if (b_x_ff <= bf2d_pkg::COL_BITS'(b_two_r_ff)) begin
         win_sum_next = bf2d_pkg::WSUM_BITS'(win_base +
                                             bf2d_pkg::WSUM_BITS'(b_col_total));
      end else begin
         win_sum_next = bf2d_pkg::WSUM_BITS'(win_base +
                                             bf2d_pkg::WSUM_BITS'(b_col_total) -
                                             bf2d_pkg::WSUM_BITS'(win_col_ff[0]));
      end
      win_sum_in = win_sum_ff;

      if (b_go && b_full) begin
         win_sum_in = win_sum_next;
         if (b_x_ff <= bf2d_pkg::COL_BITS'(b_two_r_ff)) begin
            win_col_in[b_x_ff[bf2d_pkg::TWO_R_BITS-1:0]] = b_col_total;
         end else begin
            for (int k = 0; k < bf2d_pkg::WIN_COLS - 1; k++) begin
               if (k < b_two_r_ff) begin
                  win_col_in[k] = win_col_ff[k + 1];
               end
            end
            win_col_in[b_two_r_ff] = b_col_total;
         end
      end
   end

   // ---------------------------------------------------------------- normalize
   always_comb begin
      b_v_in   = accept ? 1'b1 : (b_go ? 1'b0 : b_v_ff);
      m_v_in   = (b_go && b_has_out) ? 1'b1 : (m_go ? 1'b0 : m_v_ff);
      out_v_in = m_go ? 1'b1 : (rsp_ready ? 1'b0 : out_v_ff);

      m_prod = PROD_BITS'(PROD_BITS'(m_sum_ff) * PROD_BITS'(recip_ff) +
                          PROD_BITS'(ROUND_HALF));
      m_quot = m_prod >> bf2d_pkg::RECIP_BITS;

      rsp_data_in = rsp_data_ff;
      if (m_go) begin
         rsp_data_in.filtered = (m_quot > PROD_BITS'(PIX_MAX)) ?
                                bf2d_pkg::PIXEL_BITS'(PIX_MAX) :
                                m_quot[bf2d_pkg::PIXEL_BITS-1:0];
         rsp_data_in.last     = m_last_ff;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         column_position_ff <= '0;
         rows_filled_ff     <= '0;
         b_v_ff             <= 1'b0;
         m_v_ff             <= 1'b0;
         out_v_ff           <= 1'b0;
         win_sum_ff         <= '0;
         for (int k = 0; k < bf2d_pkg::WIN_COLS; k++) begin
            win_col_ff[k] <= '0;
         end
      end else begin
         column_position_ff <= column_position_in;
         rows_filled_ff     <= rows_filled_in;
         b_v_ff             <= b_v_in;
         m_v_ff             <= m_v_in;
         out_v_ff           <= out_v_in;
         win_sum_ff         <= win_sum_in;
         for (int k = 0; k < bf2d_pkg::WIN_COLS; k++) begin
            win_col_ff[k] <= win_col_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_x_ff     <= x_a;
         b_f_ff     <= f_a;
         b_two_r_ff <= two_r_a;
         b_pixel_ff <= req_data.pixel;
         b_fend_ff  <= req_data.frame_end;
      end
      if (b_go && b_has_out) begin
         m_sum_ff  <= win_sum_next;
         m_last_ff <= b_fend_ff;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   `BF2D_ASSERT_NEXT(a_frame_end_restart, clock, reset, req_valid && req_ready && req_data.frame_end, (column_position_ff == '0) && (rows_filled_ff == '0), "frame end did not restart the frame position")
   `BF2D_ASSERT_IMP(a_rsp_from_norm, clock, reset, $rose(rsp_valid), $past(m_v_ff), "response appeared without a normalize stage entry")
   `BF2D_ASSERT_IMP(a_norm_from_window, clock, reset, $rose(m_v_ff), $past(b_v_ff && b_full && b_has_out), "normalize stage loaded without a full window")

endmodule

// File: tb/tb_box_filter_2d_unit.sv
module tb_box_filter_2d_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import bf2d_pkg::*;

   typedef enum int {FILL_RANDOM, FILL_WHITE, FILL_BLACK, FILL_EXTREMES} fill_kind_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_payload_type           req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_payload_type           rsp_data;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   bit              idling_on;
   int unsigned     mismatch_count;
   int unsigned     pixels_sent;
   rsp_payload_type expected_pixels[$];
   rsp_payload_type oldest_pixel;

   // Shadow of the filter: registers, column store and horizontal window.
   logic [RADIUS_BITS-1:0] cfg_radius;
   logic [WIDTH_BITS-1:0]  cfg_width;
   logic [RECIP_BITS-1:0]  cfg_recip;
   logic [PIXEL_BITS-1:0]  held_pixels [TWO_R_MAX][LINE_LEN];
   logic [CSUM_BITS-1:0]   column_total [LINE_LEN];
   logic [CSUM_BITS-1:0]   window_column [WIN_COLS];
   logic [WSUM_BITS-1:0]   window_total;
   int unsigned            column_at;
   int unsigned            rows_held;

   box_filter_2d_unit u_top (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result: filtered %0d last %0d", rsp_data.filtered, rsp_data.last);
            mismatch_count++;
         end else begin
            oldest_pixel = expected_pixels.pop_front();
            if (rsp_data.filtered !== oldest_pixel.filtered) begin
               $error("filtered: expected %0d, actual %0d", oldest_pixel.filtered,
                      rsp_data.filtered);
               mismatch_count++;
            end
            if (rsp_data.last !== oldest_pixel.last) begin
               $error("last: expected %0d, actual %0d", oldest_pixel.last, rsp_data.last);
               mismatch_count++;
            end
         end
      end
   end

   function automatic int unsigned active_radius();
      if (cfg_radius < 1) return 1;
      if (cfg_radius > MAX_RADIUS) return MAX_RADIUS;
      return cfg_radius;
   endfunction

   function automatic int unsigned line_length();
      return ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width) + 2 * active_radius();
   endfunction

   function automatic int unsigned exact_recip(input int unsigned r);
      int unsigned area;
      area = (2 * r + 1) * (2 * r + 1);
      return (65536 + area / 2) / area;
   endfunction

   task automatic predict_filtered_pixel(input logic [PIXEL_BITS-1:0] pix, input logic fend);
      int unsigned                  two_r;
      int unsigned                  span;
      int unsigned                  x;
      int unsigned                  f;
      int unsigned                  k;
      logic [CSUM_BITS-1:0]         full;
      logic [WSUM_BITS+RECIP_BITS:0] scaled;
      rsp_payload_type              item;
      two_r = 2 * active_radius();
      span  = line_length();
      if (column_at >= span) column_at = 0;
      if (rows_held > two_r) rows_held = two_r;
      x = column_at;
      f = rows_held;
      if (f < two_r) begin
         column_total[x] = ((f == 0) ? '0 : column_total[x]) + pix;
         held_pixels[f][x] = pix;
      end else begin
         full = column_total[x] + pix;
         column_total[x] = full - held_pixels[0][x];
         for (k = 0; k + 1 < two_r; k++) held_pixels[k][x] = held_pixels[k+1][x];
         held_pixels[two_r-1][x] = pix;
         if (x == 0) window_total = '0;
         if (x <= two_r) begin
            window_column[x] = full;
            window_total = window_total + full;
         end else begin
            window_total = window_total + full - window_column[0];
            for (k = 0; k < two_r; k++) window_column[k] = window_column[k+1];
            window_column[two_r] = full;
         end
         if (x >= two_r) begin
            scaled = (window_total * cfg_recip + 32'd32768) >> 16;
            item.filtered = (scaled > (2**PIXEL_BITS - 1)) ? '1 : scaled[PIXEL_BITS-1:0];
            item.last = fend;
            expected_pixels.push_back(item);
         end
      end
      if (x + 1 >= span) begin
         column_at = 0;
         if (f < two_r) rows_held = f + 1;
      end else begin
         column_at = x + 1;
      end
      if (fend) begin
         column_at = 0;
         rows_held = 0;
      end
   endtask

   // Entered and left at a falling edge; valid stays high into the next request.
   task automatic push_pixel(input logic [PIXEL_BITS-1:0] pix, input logic fend);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{pixel: pix, frame_end: fend};
      do @(posedge clock); while (!(req_valid && req_ready));
      predict_filtered_pixel(pix, fend);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input int unsigned n_pixels, input fill_kind_type fill,
                             input bit close_frame);
      int unsigned           i;
      logic [PIXEL_BITS-1:0] pix;
      for (i = 0; i < n_pixels; i++) begin
         case (fill)
            FILL_WHITE:    pix = '1;
            FILL_BLACK:    pix = '0;
            FILL_EXTREMES: pix = $urandom_range(0, 1) ? '1 : '0;
            default:       pix = PIXEL_BITS'($urandom_range(0, 2**PIXEL_BITS - 1));
         endcase
         push_pixel(pix, close_frame && (i + 1 == n_pixels));
      end
   endtask

   // Requests that produce no result may still be in flight when the queue empties.
   task automatic wait_filter_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic configure_filter(input int unsigned radius_val, input int unsigned width_val,
                                   input int unsigned recip_val);
      csr_we    <= 1'b1;
      csr_index <= CSR_RADIUS;
      csr_wdata <= CSR_DATA_BITS'(radius_val);
      @(negedge clock);
      csr_index <= CSR_WIDTH;
      csr_wdata <= CSR_DATA_BITS'(width_val);
      @(negedge clock);
      csr_index <= CSR_RECIP;
      csr_wdata <= CSR_DATA_BITS'(recip_val);
      @(negedge clock);
      csr_we     <= 1'b0;
      cfg_radius = RADIUS_BITS'(radius_val);
      cfg_width  = WIDTH_BITS'(width_val);
      cfg_recip  = RECIP_BITS'(recip_val);
   endtask

   // Reset values of the registers: a short frame on the widest line gives no window.
   task automatic test_default_full_width();
      idling_on = 1'b1;
      send_frame(10, FILL_RANDOM, 1'b1);
      wait_filter_idle();
   endtask

   task automatic test_field_extremes();
      idling_on = 1'b1;
      configure_filter(1, 1, exact_recip(1));
      send_frame(8, FILL_WHITE, 1'b0);
      push_pixel('0, 1'b1);
      // A frame of one row, then a frame whose end falls on a column with no window.
      send_frame(3, FILL_RANDOM, 1'b1);
      send_frame(7, FILL_RANDOM, 1'b1);
      wait_filter_idle();
      configure_filter(1, 1, 16'hFFFF);
      send_frame(9, FILL_WHITE, 1'b1);
      wait_filter_idle();
   endtask

   task automatic test_size_clamps();
      idling_on = 1'b1;
      // Radius and width above their maxima; too few rows for any window.
      configure_filter(15, 2047, 16'hFFFF);
      send_frame(20, FILL_RANDOM, 1'b1);
      wait_filter_idle();
      // Zero width leaves a line too short to ever fill a window.
      configure_filter(0, 0, exact_recip(1));
      send_frame(10, FILL_RANDOM, 1'b1);
      wait_filter_idle();
      configure_filter(15, 1, exact_recip(MAX_RADIUS));
      send_frame(17 * line_length(), FILL_RANDOM, 1'b1);
      wait_filter_idle();
   endtask

   task automatic test_midframe_reconfig();
      idling_on = 1'b1;
      configure_filter(2, 4, exact_recip(2));
      send_frame(5 * line_length(), FILL_RANDOM, 1'b0);
      wait_filter_idle();
      // Smaller radius at a row boundary: the row count is clamped to the new 2r.
      configure_filter(1, 4, exact_recip(1));
      send_frame(2 * line_length() + 4, FILL_RANDOM, 1'b0);
      wait_filter_idle();
      // Narrower line while the column is past its end: the row restarts at column 0.
      configure_filter(1, 1, exact_recip(1));
      send_frame(3 * line_length(), FILL_RANDOM, 1'b1);
      wait_filter_idle();
   endtask

   task automatic test_random_frames();
      int unsigned first_pixel;
      int unsigned rad;
      int unsigned wid;
      int unsigned recip;
      int unsigned r;
      int unsigned span;
      int unsigned n_pixels;
      int unsigned pick;
      fill_kind_type fill;
      first_pixel = pixels_sent;
      while (pixels_sent < first_pixel + 30) begin
         idling_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, 7);
            if (pick < 6) rad = $urandom_range(1, 2);
            else if (pick == 6) rad = 0;
            else rad = 3;
            pick = $urandom_range(0, 9);
            if (pick == 0) wid = 0;
            else wid = $urandom_range(1, 4);
            r = (rad < 1) ? 1 : (rad > MAX_RADIUS) ? MAX_RADIUS : rad;
            pick = $urandom_range(0, 7);
            if (pick == 0) recip = $urandom_range(0, 16'hFFFF);
            else if (pick == 1) recip = 16'hFFFF;
            else if (pick == 2) recip = 0;
            else recip = exact_recip(r);
            wait_filter_idle();
            configure_filter(rad, wid, recip);
         end
         r    = active_radius();
         span = line_length();
         if ($urandom_range(0, 4) == 0)
            n_pixels = $urandom_range(1, span * (2 * r + 2));
         else
            n_pixels = span * (2 * r + 1 + $urandom_range(0, 1));
         pick = $urandom_range(0, 7);
         if (pick == 0) fill = FILL_WHITE;
         else if (pick == 1) fill = FILL_BLACK;
         else if (pick == 2) fill = FILL_EXTREMES;
         else fill = FILL_RANDOM;
         send_frame(n_pixels, fill, 1'b1);
      end
      wait_filter_idle();
   endtask

   // Back-to-back frames at full rate, no stalls on either side.
   task automatic test_streaming_tail();
      int unsigned i;
      idling_on = 1'b0;
      configure_filter(1, 2, exact_recip(1));
      for (i = 0; i < 3; i++) send_frame(line_length() * $urandom_range(3, 4), FILL_RANDOM, 1'b1);
      wait_filter_idle();
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_RADIUS;
      csr_wdata = '0;
      idling_on = 1'b0;
      mismatch_count = 0;
      pixels_sent    = 0;
      cfg_radius   = RADIUS_RESET;
      cfg_width    = WIDTH_RESET;
      cfg_recip    = RECIP_RESET;
      window_total = '0;
      column_at    = 0;
      rows_held    = 0;
      foreach (window_column[k]) window_column[k] = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_full_width();
      test_field_extremes();
      test_size_clamps();
      test_midframe_reconfig();
      test_random_frames();
      test_streaming_tail();

      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: box_filter_2d_unit.f
+incdir+design
design/bf2d_pkg.sv
design/bf2d_col_store.sv
design/box_filter_2d_unit.sv
tb/tb_box_filter_2d_unit.sv
